// File: rtl/fa_pkg.sv
// ----------------------------------------------------------------------------
// fa_pkg: shared types and constants of the finite automaton acceptor
// Beat layouts, operation and register codes, table entry packing and the
// state existence helper.
// ----------------------------------------------------------------------------
package fa_pkg;

    // Sizing defaults
    localparam int FA_MAX_STATES      = 16;
    localparam int FA_MAX_TRANSITIONS = 64;

    // Field widths
    localparam int OP_W           = 2;
    localparam int ENTRY_INDEX_W  = 6;
    localparam int STATE_W        = 4;
    localparam int SYMBOL_W       = 8;
    localparam int STATE_SET_W    = 16;
    localparam int COUNT_W        = 16;
    localparam int TR_COUNT_W     = 7;
    localparam int ENTRY_W        = STATE_W + SYMBOL_W + STATE_W;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // Operation codes of an input beat
    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_FEED = 2'd1,
        OP_END  = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DET_MODE    = 2'd0,
        CFG_START_STATE = 2'd1,
        CFG_FINAL_MASK  = 2'd2,
        CFG_TR_COUNT    = 2'd3
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_fa_state;

    // Input beat
    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [STATE_W-1:0]       entry_source;
        logic [SYMBOL_W-1:0]      entry_symbol;
        logic [STATE_W-1:0]       entry_target;
        logic [SYMBOL_W-1:0]      symbol;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic                   accepted;
        logic                   stalled;
        logic [STATE_SET_W-1:0] reached_states;
        logic [COUNT_W-1:0]     symbols_seen;
    } t_out_beat;

    // Table entry as stored in the RAM
    typedef struct packed {
        logic [STATE_W-1:0]  source;
        logic [SYMBOL_W-1:0] symbol;
        logic [STATE_W-1:0]  target;
    } t_entry;

    // One-hot bit of a state, zero when the state does not exist
    function automatic logic [STATE_SET_W-1:0] state_bit(input logic [STATE_W-1:0] s);
        logic [STATE_SET_W-1:0] b;
        b = '0;
        if (int'(s) < FA_MAX_STATES) begin
            b = STATE_SET_W'(1) << s;
        end
        return b;
    endfunction

endpackage

// File: rtl/fa_stream_if.sv
// ----------------------------------------------------------------------------
// fa_stream_if: valid/ready channel
// Carries one payload beat per handshake; the type is set per instance.
// ----------------------------------------------------------------------------
interface fa_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/fa_ram.sv
// ----------------------------------------------------------------------------
// fa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/finite_automaton_acceptor.sv
// ----------------------------------------------------------------------------
// finite_automaton_acceptor: byte stream acceptor for a table-driven automaton
// Runs a deterministic (first match) or set-of-states automaton over fed
// symbols and reports the verdict on each end beat.
//
//   channel  | dir | beat                                  | handshake
//   ---------+-----+---------------------------------------+-------------
//   i_in     | in  | load entry / feed symbol / end string | valid/ready
//   o_out    | out | accepted, stalled, reached, count     | valid/ready
//   i_cfg_*  | in  | register index and data               | write enable
//
// A feed beat is accepted, then the table RAM is read one entry per scan cycle
// into a single entry comparator, up to live = min(transition_count,
// MAX_TRANSITIONS) entries; once the registered read data of the last entry
// is folded, the new set is committed.
// Reset clears the sequencer, registers and string state; the table RAM is
// not cleared and holds garbage until loaded.
// i_in.ready is low during a scan and while an unread result holds o_out.
// ----------------------------------------------------------------------------
module finite_automaton_acceptor
    import fa_pkg::*;
#(
    parameter int MAX_TRANSITIONS = FA_MAX_TRANSITIONS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fa_stream_if.sink             i_in,
    fa_stream_if.source           o_out
);

    localparam int AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CW = $clog2(MAX_TRANSITIONS + 1);
    localparam int XW = (AW > ENTRY_INDEX_W) ? AW : ENTRY_INDEX_W;

    // Configuration registers
    logic                   r_det;
    logic [STATE_W-1:0]     r_start;
    logic [STATE_SET_W-1:0] r_final;
    logic [TR_COUNT_W-1:0]  r_tr_count;

    // Sequencer and string state
    t_fa_state              r_state,     n_state;
    logic                   r_armed,     n_armed;
    logic                   r_stall,     n_stall;
    logic [STATE_SET_W-1:0] r_active,    n_active;
    logic [COUNT_W-1:0]     r_cnt,       n_cnt;

    // Scan working registers
    logic [STATE_SET_W-1:0] r_mask,      n_mask;
    logic [STATE_SET_W-1:0] r_next,      n_next;
    logic                   r_hit,       n_hit;
    logic [CW-1:0]          r_addr,      n_addr;
    logic                   r_pend,      n_pend;
    logic [SYMBOL_W-1:0]    r_sym,       n_sym;

    // Result register
    logic                   r_out_valid, n_out_valid;
    t_out_beat              r_out,       n_out;

    logic                   w_in_fire;
    logic                   w_out_fire;
    t_in_beat               w_in;
    logic [CW-1:0]          w_live;
    logic                   w_we;
    logic [XW-1:0]          w_idx_ext;
    logic                   w_re;
    logic [ENTRY_W-1:0]     w_rdata;
    t_entry                 w_entry;
    logic [STATE_SET_W-1:0] w_tgt_bit;
    logic                   w_match;
    logic [STATE_SET_W-1:0] w_act0;
    logic                   w_stall0;
    logic [COUNT_W-1:0]     w_cnt0;
    logic [STATE_SET_W-1:0] w_reached;

    // Handshakes
    assign w_in       = i_in.payload;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Clamp the live entry count to the table depth
    assign w_live = (int'(r_tr_count) > MAX_TRANSITIONS) ? CW'(MAX_TRANSITIONS)
                                                          : CW'(r_tr_count);

    // Table write on load beats inside the table
    assign w_idx_ext = XW'(w_in.entry_index);
    assign w_we      = w_in_fire && (w_in.operation == OP_LOAD)
                       && (int'(w_in.entry_index) < MAX_TRANSITIONS);

    // Table read: one entry per scan cycle
    assign w_re = (r_state == ST_SCAN) && (r_addr < w_live);

    fa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TRANSITIONS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(w_idx_ext)),
        .i_wdata ({w_in.entry_source, w_in.entry_symbol, w_in.entry_target}),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Shared entry comparator
    assign w_entry   = t_entry'(w_rdata);
    assign w_tgt_bit = state_bit(w_entry.target);
    assign w_match   = r_pend && r_mask[w_entry.source]
                       && (int'(w_entry.source) < FA_MAX_STATES)
                       && (w_entry.symbol == r_sym) && (w_tgt_bit != '0);

    // String state as seen by a feed or end beat, armed if idle
    assign w_act0    = r_armed ? r_active : state_bit(r_start);
    assign w_stall0  = r_armed && r_stall;
    assign w_cnt0    = r_armed ? r_cnt : '0;
    assign w_reached = w_stall0 ? '0 : w_act0;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det      <= 1'b0;
            r_start    <= '0;
            r_final    <= '0;
            r_tr_count <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_DET_MODE:    r_det      <= i_cfg_data[0];
                CFG_START_STATE: r_start    <= i_cfg_data[STATE_W-1:0];
                CFG_FINAL_MASK:  r_final    <= i_cfg_data[STATE_SET_W-1:0];
                CFG_TR_COUNT:    r_tr_count <= i_cfg_data[TR_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_armed     = r_armed;
        n_stall     = r_stall;
        n_active    = r_active;
        n_cnt       = r_cnt;
        n_mask      = r_mask;
        n_next      = r_next;
        n_hit       = r_hit;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_sym       = r_sym;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // Drop a result once taken
        if (w_out_fire) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    case (w_in.operation)
                        OP_FEED: begin
                            n_armed  = 1'b1;
                            n_active = w_act0;
                            n_stall  = w_stall0;
                            n_cnt    = (w_cnt0 != '1) ? w_cnt0 + COUNT_W'(1) : w_cnt0;
                            if (!w_stall0) begin
                                n_mask  = r_det ? (w_act0 & (~w_act0 + STATE_SET_W'(1)))
                                                : w_act0;
                                n_next  = '0;
                                n_hit   = 1'b0;
                                n_addr  = '0;
                                n_pend  = 1'b0;
                                n_sym   = w_in.symbol;
                                n_state = ST_SCAN;
                            end
                        end
                        OP_END: begin
                            n_out.accepted       = !w_stall0 && ((w_reached & r_final) != '0);
                            n_out.stalled        = w_stall0;
                            n_out.reached_states = w_reached;
                            n_out.symbols_seen   = w_cnt0;
                            n_out_valid          = 1'b1;
                            n_armed              = 1'b0;
                            n_stall              = 1'b0;
                            n_active             = '0;
                            n_cnt                = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // Advance the read address
                n_pend = w_re;
                if (w_re) begin
                    n_addr = r_addr + CW'(1);
                end
                // Fold the entry read last cycle
                if (w_match) begin
                    n_hit = 1'b1;
                    if (!r_det) begin
                        n_next = r_next | w_tgt_bit;
                    end else if (!r_hit) begin
                        n_next = w_tgt_bit;
                    end
                end
                // Commit once all entries are folded
                if (!w_re && !r_pend) begin
                    n_active = r_hit ? r_next : '0;
                    n_stall  = !r_hit;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_armed     <= 1'b0;
            r_stall     <= 1'b0;
            r_active    <= '0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_armed     <= n_armed;
            r_stall     <= n_stall;
            r_active    <= n_active;
            r_cnt       <= n_cnt;
            r_hit       <= n_hit;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        r_next <= n_next;
        r_sym  <= n_sym;
        r_out  <= n_out;
    end

endmodule

// File: tb/sv/fa_acceptor_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fa_acceptor_tb_pkg: verdict prediction for the automaton acceptor bench
// Keeps a private copy of the registers, the transition table and the string
// state, works out the verdict of every end beat and checks the result beats
// against those verdicts in order.
// ----------------------------------------------------------------------------
package fa_acceptor_tb_pkg;

    import fa_pkg::*;

    // Operation code that the block must ignore
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    class verdict_predictor;
        t_entry                 entries [FA_MAX_TRANSITIONS];
        logic                   det_mode;
        logic [STATE_W-1:0]     start_state;
        logic [STATE_SET_W-1:0] final_mask;
        logic [TR_COUNT_W-1:0]  tr_count;
        logic [STATE_SET_W-1:0] active_set;
        logic                   armed;
        logic                   stalled;
        logic [COUNT_W-1:0]     seen;
        t_out_beat              pending_verdicts [$];
        int unsigned            failures;

        function new();
            foreach (entries[i]) entries[i] = '0;
            det_mode    = 1'b0;
            start_state = '0;
            final_mask  = '0;
            tr_count    = '0;
            active_set  = '0;
            armed       = 1'b0;
            stalled     = 1'b0;
            seen        = '0;
            failures    = 0;
        endfunction

        function logic [STATE_SET_W-1:0] one_hot(input logic [STATE_W-1:0] s);
            return STATE_SET_W'(1) << s;
        endfunction

        // Entries that take part in a scan
        function int unsigned live_entries();
            if (tr_count > FA_MAX_TRANSITIONS) return FA_MAX_TRANSITIONS;
            return int'(tr_count);
        endfunction

        // Start a fresh string on the first feed or end after an end
        function void arm();
            if (!armed) begin
                active_set = one_hot(start_state);
                stalled    = 1'b0;
                seen       = '0;
                armed      = 1'b1;
            end
        endfunction

        function void write_register(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DET_MODE:    det_mode    = data[0];
                CFG_START_STATE: start_state = data[STATE_W-1:0];
                CFG_FINAL_MASK:  final_mask  = data[STATE_SET_W-1:0];
                CFG_TR_COUNT:    tr_count    = data[TR_COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted input beat to the predicted state
        function void note_beat(input t_in_beat b);
            int unsigned            live;
            int unsigned            i;
            int                     cur;
            logic [STATE_SET_W-1:0] next_set;
            logic                   hit;
            t_out_beat              v;
            case (b.operation)
                OP_LOAD: begin
                    entries[b.entry_index].source = b.entry_source;
                    entries[b.entry_index].symbol = b.entry_symbol;
                    entries[b.entry_index].target = b.entry_target;
                end
                OP_FEED: begin
                    arm();
                    if (seen != '1) seen = seen + COUNT_W'(1);
                    if (!stalled) begin
                        live     = live_entries();
                        next_set = '0;
                        hit      = 1'b0;
                        if (det_mode) begin
                            // lowest active state is the current one
                            cur = -1;
                            for (i = 0; i < STATE_SET_W; i++) begin
                                if (cur < 0 && active_set[i]) cur = int'(i);
                            end
                            if (cur >= 0) begin
                                for (i = 0; i < live; i++) begin
                                    if (!hit && entries[i].source == STATE_W'(cur) &&
                                        entries[i].symbol == b.symbol) begin
                                        next_set = one_hot(entries[i].target);
                                        hit      = 1'b1;
                                    end
                                end
                            end
                        end else begin
                            for (i = 0; i < live; i++) begin
                                if (active_set[entries[i].source] &&
                                    entries[i].symbol == b.symbol) begin
                                    next_set = next_set | one_hot(entries[i].target);
                                    hit      = 1'b1;
                                end
                            end
                        end
                        if (hit) begin
                            active_set = next_set;
                        end else begin
                            active_set = '0;
                            stalled    = 1'b1;
                        end
                    end
                end
                OP_END: begin
                    arm();
                    v.stalled        = stalled;
                    v.reached_states = stalled ? '0 : active_set;
                    v.accepted       = !stalled && ((v.reached_states & final_mask) != '0);
                    v.symbols_seen   = seen;
                    pending_verdicts.push_back(v);
                    active_set = '0;
                    stalled    = 1'b0;
                    seen       = '0;
                    armed      = 1'b0;
                end
                default: ;
            endcase
        endfunction

        // Compare a result beat with the oldest predicted verdict
        function void check_verdict(input t_out_beat got);
            t_out_beat want;
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no verdict pending: %h", got);
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                failures++;
            end
            if (got.stalled !== want.stalled) begin
                $error("stalled: expected %0d, got %0d", want.stalled, got.stalled);
                failures++;
            end
            if (got.reached_states !== want.reached_states) begin
                $error("reached_states: expected %h, got %h",
                       want.reached_states, got.reached_states);
                failures++;
            end
            if (got.symbols_seen !== want.symbols_seen) begin
                $error("symbols_seen: expected %0d, got %0d",
                       want.symbols_seen, got.symbols_seen);
                failures++;
            end
        endfunction
    endclass

endpackage

// File: tb/sv/tb_finite_automaton_acceptor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_finite_automaton_acceptor: self-checking bench of the automaton acceptor
// Programs small random automata, runs strings steered along live transitions
// in both scan modes, with noise, reloads, mode switches mid-string and table
// counts past the end. Every verdict beat is checked against a predictor
// under random source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_finite_automaton_acceptor;

    import fa_pkg::*;
    import fa_acceptor_tb_pkg::*;

    localparam int unsigned SETTLE_CYCLES      = 80;
    localparam int unsigned HOLD_OFF_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT     = 2000;
    localparam int unsigned RANDOM_PHASES      = 14;
    localparam int unsigned PHASE_STRING_ITEMS = 30;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fa_stream_if #(.t_payload(t_in_beat))  in_if ();
    fa_stream_if #(.t_payload(t_out_beat)) out_if ();

    verdict_predictor    verdicts;
    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         hold_off_left  = 0;
    int unsigned         quiet_cycles   = 0;
    logic [SYMBOL_W-1:0] alphabet [3];
    logic [STATE_W-1:0]  states [4];

    finite_automaton_acceptor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Take result beats, stalling at random or for a counted hold-off
    always @(posedge i_clk) begin
        if (hold_off_left != 0) begin
            hold_off_left = hold_off_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check result beats and watch for a stuck handshake
    always @(posedge i_clk) begin
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            verdicts.check_verdict(out_if.payload);
        end
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_finite_automaton_acceptor NOT OK");
            $finish;
        end
    end

    // Offer one beat, idling first at random, and hold it until accepted
    task automatic push_beat(input t_in_beat b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= b;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        verdicts.note_beat(b);
    endtask

    task automatic send_load(input int unsigned idx, input logic [STATE_W-1:0] src,
                             input logic [SYMBOL_W-1:0] sym, input logic [STATE_W-1:0] dst);
        t_in_beat b;
        b              = t_in_beat'($urandom);
        b.operation    = OP_LOAD;
        b.entry_index  = ENTRY_INDEX_W'(idx);
        b.entry_source = src;
        b.entry_symbol = sym;
        b.entry_target = dst;
        push_beat(b);
    endtask

    // Feed, end or reserved beat; the unused fields carry random bits
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SYMBOL_W-1:0] sym);
        t_in_beat b;
        b           = t_in_beat'($urandom);
        b.operation = op;
        b.symbol    = sym;
        push_beat(b);
    endtask

    // Drop valid and wait for every verdict, then let a scan finish if asked
    task automatic drain(input bit settle);
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (verdicts.pending_verdicts.size() != 0);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic drive_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        verdicts.write_register(idx, data);
    endtask

    // Write all registers while the block is idle
    task automatic apply_setting(input logic det, input logic [STATE_W-1:0] start,
                                 input logic [STATE_SET_W-1:0] mask,
                                 input logic [TR_COUNT_W-1:0] count);
        drain(1'b1);
        drive_reg(CFG_DET_MODE, CFG_DATA_W'(det));
        drive_reg(CFG_START_STATE, CFG_DATA_W'(start));
        drive_reg(CFG_FINAL_MASK, CFG_DATA_W'(mask));
        drive_reg(CFG_TR_COUNT, CFG_DATA_W'(count));
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_traffic(input int unsigned profile);
        case (profile)
            1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
            3:       begin send_idle_pct = 24; recv_stall_pct = 24; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Strings mostly steered along live transitions, with noise mixed in
    task automatic run_strings(input int unsigned budget);
        int unsigned         sent;
        int unsigned         len;
        int unsigned         k;
        int unsigned         r;
        int unsigned         tries;
        int unsigned         e;
        int unsigned         live;
        logic [SYMBOL_W-1:0] sym;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 10);
            for (k = 0; k < len; k++) begin
                r = $urandom_range(99);
                if (r < 4) begin
                    send_item(OP_RESERVED, 8'($urandom));
                end else if (r < 8) begin
                    send_load($urandom_range(FA_MAX_TRANSITIONS - 1), 4'($urandom),
                              alphabet[$urandom_range(2)], 4'($urandom));
                end else begin
                    // try to pick a symbol that some active entry consumes
                    sym  = 8'($urandom);
                    live = verdicts.live_entries();
                    if (r < 28) begin
                        sym = alphabet[$urandom_range(2)];
                    end else if (r < 92 && live != 0) begin
                        for (tries = 0; tries < 8; tries++) begin
                            e = $urandom_range(live - 1);
                            if (verdicts.active_set[verdicts.entries[e].source]) begin
                                sym = verdicts.entries[e].symbol;
                            end
                        end
                    end
                    send_item(OP_FEED, sym);
                end
            end
            sent += len;
            if ($urandom_range(9) != 0) begin
                send_item(OP_END, 8'($urandom));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int unsigned           p;
        int unsigned           n;
        int unsigned           k;
        logic [TR_COUNT_W-1:0] count;
        logic [STATE_W-1:0]    start;
        logic [STATE_SET_W-1:0] mask;

        verdicts      = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_DET_MODE;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty string after reset, then a stall on an empty table
        set_traffic(0);
        send_item(OP_END, 8'h00);
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_RESERVED, 8'h5A);
        send_item(OP_END, 8'hFF);

        // Set-of-states run from the top state
        apply_setting(1'b0, 4'd15, 16'h8001, 7'd3);
        send_load(0, 4'd15, 8'hFF, 4'd0);
        send_load(1, 4'd15, 8'hFF, 4'd15);
        send_load(2, 4'd0, 8'h00, 4'd15);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_FEED, 8'h00);
        send_item(OP_END, 8'h00);

        // Leave two states active across a switch to first-match mode
        send_item(OP_FEED, 8'hFF);
        apply_setting(1'b1, 4'd15, 16'h0001, 7'd3);
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_END, 8'h00);

        // Reload a live entry mid-string
        send_item(OP_FEED, 8'hFF);
        send_load(2, 4'd0, 8'hAA, 4'd5);
        send_item(OP_FEED, 8'hAA);
        send_item(OP_END, 8'h00);

        // Random automata, one setting per phase
        for (p = 0; p < RANDOM_PHASES; p++) begin
            set_traffic(p % 4);
            n     = $urandom_range(1, 12);
            count = TR_COUNT_W'(n);
            case (p)
                3:  begin n = FA_MAX_TRANSITIONS; count = 7'd127; end
                6:  begin n = 0; count = 7'd0; end
                8:  begin n = FA_MAX_TRANSITIONS; count = 7'd64; end
                10: begin n = FA_MAX_TRANSITIONS; count = TR_COUNT_W'($urandom_range(65, 126)); end
                default: ;
            endcase
            start = (p == 1) ? 4'd0 : (p == 2) ? 4'd15 : 4'($urandom);
            mask  = (p == 4) ? 16'h0000 : (p == 5) ? 16'hFFFF : 16'($urandom);
            apply_setting(1'($urandom), start, mask, count);

            states[0] = start;
            for (k = 1; k < 4; k++) states[k] = 4'($urandom);
            for (k = 0; k < 3; k++) alphabet[k] = 8'($urandom);
            for (k = 0; k < n; k++) begin
                send_load(k, states[$urandom_range(3)], alphabet[$urandom_range(2)],
                          states[$urandom_range(3)]);
            end

            run_strings(PHASE_STRING_ITEMS / 2);
            if (p == 5) begin
                // sink holds off while beats keep coming
                hold_off_left = HOLD_OFF_CYCLES;
            end else if (p == 7) begin
                drain(1'b0);
            end
            run_strings(PHASE_STRING_ITEMS / 2);
        end

        drain(1'b1);
        if (verdicts.failures == 0 && verdicts.pending_verdicts.size() == 0) begin
            $display("tb_finite_automaton_acceptor OK");
        end else begin
            $display("tb_finite_automaton_acceptor NOT OK");
        end
        $finish;
    end

endmodule
